[hw/rtl/marching_tetrahedra_cell_triangulator_top_macros.svh]
// Assertion macros for the triangulator checker.
// Used by mtt_checker only; needs nothing else.
`ifndef MARCHING_TETRAHEDRA_CELL_TRIANGULATOR_TOP_MACROS_SVH
`define MARCHING_TETRAHEDRA_CELL_TRIANGULATOR_TOP_MACROS_SVH

// property checked outside reset
`define MTT_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("triangulator port check failed");

// property that looks at reset itself
`define MTT_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("triangulator reset check failed");

`endif

[hw/rtl/mtt_pkg.sv]
// Shared constants, types and lookup tables of the triangulator.
// No dependencies.
`default_nettype none

package mtt_pkg;

    localparam int FB             = 16;
    localparam int IDX_W          = 10;
    localparam int CELL_INDEX_MAX = 1022;
    localparam int VAL_W          = 32;
    localparam int TOL_W          = 16;
    localparam int DW             = VAL_W + 1;
    localparam int CW             = IDX_W + FB;
    localparam int NTET           = 6;
    localparam int NJOB           = 2 * NTET;
    localparam int JOB_W          = $clog2(NJOB);
    localparam int QDEPTH         = 4;
    localparam int QPTR_W         = $clog2(QDEPTH);
    localparam int CFG_IDX_W      = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ISO_LEVEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SNAP_TOL  = 2'd1;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [VAL_W-1:0] t_val;
    typedef logic [CW-1:0]    t_coord;

    localparam t_coord COORD_MAX = t_coord'((CELL_INDEX_MAX + 1) << FB);

    // one classified cell, as queued between front and back
    typedef struct packed {
        logic [2:0][IDX_W-1:0]   base;
        logic [7:0][VAL_W-1:0]   val;
        logic [NTET-1:0][3:0]    tidx;
        logic [NJOB-1:0]         jobs;
    } t_cell;

    // one triangle: [vertex][axis]
    typedef struct packed {
        logic [2:0][2:0][CW-1:0] v;
        logic                    fin;
    } t_tri;

    // cube corners of tetrahedron t, vertex n
    function automatic logic [2:0] tet_corner(input logic [2:0] t, input logic [1:0] n);
        logic [11:0] row;
        case (t)
            3'd0:    row = {3'd7, 3'd3, 3'd2, 3'd0};
            3'd1:    row = {3'd7, 3'd6, 3'd2, 3'd0};
            3'd2:    row = {3'd7, 3'd6, 3'd4, 3'd0};
            3'd3:    row = {3'd2, 3'd1, 3'd6, 3'd0};
            3'd4:    row = {3'd4, 3'd1, 3'd6, 3'd0};
            3'd5:    row = {3'd4, 3'd1, 3'd6, 3'd5};
            default: row = '0;
        endcase
        return row[n*3 +: 3];
    endfunction

    // corner offset as {dz, dy, dx}
    function automatic logic [2:0] corner_off(input logic [2:0] c);
        logic [2:0] o;
        case (c)
            3'd0:    o = 3'b000;
            3'd1:    o = 3'b010;
            3'd2:    o = 3'b011;
            3'd3:    o = 3'b001;
            3'd4:    o = 3'b100;
            3'd5:    o = 3'b110;
            3'd6:    o = 3'b111;
            3'd7:    o = 3'b101;
            default: o = 3'b000;
        endcase
        return o;
    endfunction

    function automatic logic [1:0] tri_count(input logic [3:0] idx);
        logic [1:0] n;
        case (idx)
            4'd0, 4'd15:                      n = 2'd0;
            4'd3, 4'd5, 4'd6, 4'd9, 4'd10, 4'd12: n = 2'd2;
            default:                          n = 2'd1;
        endcase
        return n;
    endfunction

    // edges {r1v2, r1v1, r1v0, r0v2, r0v1, r0v0}, each (first << 4) | second
    function automatic logic [47:0] tri_edges(input logic [3:0] idx);
        logic [47:0] e;
        case (idx)
            4'd1, 4'd14: e = {8'h00, 8'h00, 8'h00, 8'h03, 8'h02, 8'h01};
            4'd2, 4'd13: e = {8'h00, 8'h00, 8'h00, 8'h12, 8'h13, 8'h10};
            4'd3, 4'd12: e = {8'h02, 8'h12, 8'h13, 8'h13, 8'h02, 8'h03};
            4'd4, 4'd11: e = {8'h00, 8'h00, 8'h00, 8'h23, 8'h21, 8'h20};
            4'd5, 4'd10: e = {8'h23, 8'h12, 8'h01, 8'h03, 8'h23, 8'h01};
            4'd6, 4'd9:  e = {8'h23, 8'h02, 8'h01, 8'h23, 8'h13, 8'h01};
            4'd7, 4'd8:  e = {8'h00, 8'h00, 8'h00, 8'h31, 8'h32, 8'h30};
            default:     e = '0;
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/mtt_front.sv]
// Front end: accepts a cell, clamps indices, classifies the six tetrahedra.
// Depends on mtt_pkg.
`default_nettype none

module mtt_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mtt_pkg::t_idx       i_cell_x,
    input  mtt_pkg::t_idx       i_cell_y,
    input  mtt_pkg::t_idx       i_cell_z,
    input  logic [7:0][mtt_pkg::VAL_W-1:0] i_corner,
    input  mtt_pkg::t_val       i_iso,
    output logic                o_push,
    output mtt_pkg::t_cell      o_cell,
    input  logic                i_q_ready
);
    import mtt_pkg::*;

    logic  r_valid;
    t_cell r_cell;
    t_cell n_cell;
    logic  accept;
    logic [7:0] below;

    assign o_in_ready = !r_valid || i_q_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = r_valid;
    assign o_cell     = r_cell;

    function automatic t_idx clamp(input t_idx v);
        return (v > t_idx'(CELL_INDEX_MAX)) ? t_idx'(CELL_INDEX_MAX) : v;
    endfunction

    // classify: below-level bits, per-tetra index and job mask
    always_comb begin
        n_cell.base[0] = clamp(i_cell_x);
        n_cell.base[1] = clamp(i_cell_y);
        n_cell.base[2] = clamp(i_cell_z);
        n_cell.val     = i_corner;
        for (int c = 0; c < 8; c++) begin
            below[c] = $signed(i_corner[c]) < $signed(i_iso);
        end
        for (int t = 0; t < NTET; t++) begin
            for (int n = 0; n < 4; n++) begin
                n_cell.tidx[t][n] = below[tet_corner(3'(t), 2'(n))];
            end
            n_cell.jobs[2*t]     = tri_count(n_cell.tidx[t]) != 2'd0;
            n_cell.jobs[2*t + 1] = tri_count(n_cell.tidx[t]) == 2'd2;
        end
    end

    // empty cells are dropped here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= accept && (n_cell.jobs != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cell <= n_cell;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/mtt_queue.sv]
// Short queue of classified cells between front and back.
// Depends on mtt_pkg.
`default_nettype none

module mtt_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mtt_pkg::t_cell i_cell,
    output logic           o_ready,
    input  logic           i_pop,
    output logic           o_valid,
    output mtt_pkg::t_cell o_cell
);
    import mtt_pkg::*;

    t_cell             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_head;
    logic [QPTR_W-1:0] r_tail;
    logic [QPTR_W:0]   r_count;
    logic              do_push;
    logic              do_pop;

    assign o_ready = r_count != (QPTR_W+1)'(QDEPTH);
    assign o_valid = r_count != '0;
    assign o_cell  = r_mem[r_head];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_tail <= r_tail + 1'b1;
            end
            if (do_pop) begin
                r_head <= r_head + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_tail] <= i_cell;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/mtt_back.sv]
// Back end: walks the triangle jobs of each cell and places the vertices
// through a pipelined divider. Depends on mtt_pkg.
`default_nettype none

module mtt_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_q_valid,
    input  mtt_pkg::t_cell            i_q_cell,
    output logic                      o_q_pop,
    input  mtt_pkg::t_val             i_iso,
    input  logic [mtt_pkg::TOL_W-1:0] i_tol,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output mtt_pkg::t_tri             o_tri
);
    import mtt_pkg::*;

    typedef struct packed {
        logic [2:0] a;
        logic [2:0] b;
        t_val       va;
        t_val       vb;
    } t_l1;

    typedef struct packed {
        logic [2:0]    a;
        logic [2:0]    b;
        logic [DW-1:0] num;
        logic [DW-1:0] den;
        logic [DW-1:0] eb;
    } t_l2;

    typedef struct packed {
        logic [2:0]    s;
        logic [2:0]    bb;
        logic          use_div;
        logic [FB:0]   preset;
        logic [DW-1:0] n;
        logic [DW-1:0] d;
    } t_l3;

    typedef struct packed {
        logic [2:0]    s;
        logic [2:0]    bb;
        logic          use_div;
        logic [FB:0]   preset;
        logic [DW-1:0] d;
        logic [DW:0]   rem;
        logic [FB-1:0] xlo;
        logic [FB-1:0] q;
    } t_dl;

    typedef struct packed {
        logic                  fin;
        logic [2:0][IDX_W-1:0] base;
    } t_hdr;

    localparam logic [FB:0] MU_ONE = {1'b1, {FB{1'b0}}};

    // sequencer
    t_cell            r_cur;
    logic [NJOB-1:0]  r_mask;
    logic [NJOB-1:0]  rest;
    logic [JOB_W-1:0] pick_j;
    logic             adv;
    logic             issue;

    // pipeline registers
    logic             r_v1, r_v2, r_v3;
    t_hdr             r_h1, r_h2, r_h3;
    t_l1 [2:0]        r_l1;
    t_l2 [2:0]        r_l2;
    t_l3 [2:0]        r_l3;
    logic             r_dv [FB+1];
    t_hdr             r_dh [FB+1];
    t_dl [2:0]        r_dl [FB+1];
    logic             r_ov;
    t_tri             r_out;

    t_l1 [2:0]        n_l1;
    t_l2 [2:0]        n_l2;
    t_l3 [2:0]        n_l3;
    t_dl [2:0]        n_d0;
    t_dl [2:0]        n_dl [FB];
    t_tri             n_out;

    assign adv         = !r_ov || i_out_ready;
    assign issue       = adv && (r_mask != '0);
    assign o_out_valid = r_ov;
    assign o_tri       = r_out;

    function automatic logic [DW-1:0] mag(input logic [DW-1:0] x);
        return x[DW-1] ? (~x + 1'b1) : x;
    endfunction

    // lowest pending job
    always_comb begin
        pick_j = '0;
        for (int k = NJOB - 1; k >= 0; k--) begin
            if (r_mask[k]) begin
                pick_j = JOB_W'(k);
            end
        end
        rest = r_mask & ~(NJOB'(1) << pick_j);
    end

    assign o_q_pop = i_q_valid && ((r_mask == '0) || (issue && (rest == '0)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (o_q_pop) begin
            r_mask <= i_q_cell.jobs;
        end else if (issue) begin
            r_mask <= rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cur <= i_q_cell;
        end
    end

    // issue: edge lookup and sample selection
    always_comb begin
        logic [2:0]  t;
        logic [47:0] edges;
        logic [7:0]  e;
        t     = pick_j[JOB_W-1:1];
        edges = tri_edges(r_cur.tidx[t]);
        for (int v = 0; v < 3; v++) begin
            e          = pick_j[0] ? edges[(3 + v)*8 +: 8] : edges[v*8 +: 8];
            n_l1[v].a  = tet_corner(t, e[5:4]);
            n_l1[v].b  = tet_corner(t, e[1:0]);
            n_l1[v].va = r_cur.val[n_l1[v].a];
            n_l1[v].vb = r_cur.val[n_l1[v].b];
        end
    end

    // exact differences
    always_comb begin
        logic [DW-1:0] lvl;
        logic [DW-1:0] xa;
        logic [DW-1:0] xb;
        lvl = {i_iso[VAL_W-1], i_iso};
        for (int v = 0; v < 3; v++) begin
            xa          = {r_l1[v].va[VAL_W-1], r_l1[v].va};
            xb          = {r_l1[v].vb[VAL_W-1], r_l1[v].vb};
            n_l2[v].a   = r_l1[v].a;
            n_l2[v].b   = r_l1[v].b;
            n_l2[v].num = lvl - xa;
            n_l2[v].den = xb - xa;
            n_l2[v].eb  = lvl - xb;
        end
    end

    // snapping and range decisions
    always_comb begin
        logic [DW-1:0] mn;
        logic [DW-1:0] md;
        logic [DW-1:0] mb;
        logic [DW-1:0] tol;
        tol = {{(DW - TOL_W){1'b0}}, i_tol};
        for (int v = 0; v < 3; v++) begin
            mn = mag(r_l2[v].num);
            md = mag(r_l2[v].den);
            mb = mag(r_l2[v].eb);
            n_l3[v].n       = mn;
            n_l3[v].d       = md;
            n_l3[v].s       = r_l2[v].a;
            n_l3[v].bb      = r_l2[v].b;
            n_l3[v].use_div = 1'b0;
            n_l3[v].preset  = '0;
            if (mn < tol) begin
                n_l3[v].bb = r_l2[v].a;
            end else if (mb < tol) begin
                n_l3[v].s  = r_l2[v].b;
            end else if ((md < tol) || (r_l2[v].den == '0)) begin
                n_l3[v].bb = r_l2[v].a;
            end else if ((r_l2[v].num != '0)
                         && (r_l2[v].num[DW-1] == r_l2[v].den[DW-1])) begin
                if (mn >= md) begin
                    n_l3[v].preset = MU_ONE;
                end else begin
                    n_l3[v].use_div = 1'b1;
                end
            end
        end
    end

    // divider set-up: dividend is n * 2^FB + d / 2; when rounding lifts the
    // quotient to 2^FB the divider is bypassed with mu = one
    always_comb begin
        logic [DW+FB:0] x;
        for (int v = 0; v < 3; v++) begin
            x = {1'b0, r_l3[v].n, {FB{1'b0}}} + (DW+FB+1)'(r_l3[v].d >> 1);
            n_d0[v].s       = r_l3[v].s;
            n_d0[v].bb      = r_l3[v].bb;
            n_d0[v].use_div = r_l3[v].use_div;
            n_d0[v].preset  = r_l3[v].preset;
            if (r_l3[v].use_div && (x[DW+FB:FB] >= {1'b0, r_l3[v].d})) begin
                n_d0[v].use_div = 1'b0;
                n_d0[v].preset  = MU_ONE;
            end
            n_d0[v].d       = r_l3[v].d;
            n_d0[v].rem     = x[DW+FB:FB];
            n_d0[v].xlo     = x[FB-1:0];
            n_d0[v].q       = '0;
        end
    end

    // one quotient bit per stage
    always_comb begin
        logic [DW:0] tr;
        for (int k = 0; k < FB; k++) begin
            for (int v = 0; v < 3; v++) begin
                n_dl[k][v] = r_dl[k][v];
                tr = {r_dl[k][v].rem[DW-1:0], r_dl[k][v].xlo[FB-1]};
                n_dl[k][v].xlo = {r_dl[k][v].xlo[FB-2:0], 1'b0};
                if (tr >= {1'b0, r_dl[k][v].d}) begin
                    n_dl[k][v].rem = tr - {1'b0, r_dl[k][v].d};
                    n_dl[k][v].q   = {r_dl[k][v].q[FB-2:0], 1'b1};
                end else begin
                    n_dl[k][v].rem = tr;
                    n_dl[k][v].q   = {r_dl[k][v].q[FB-2:0], 1'b0};
                end
            end
        end
    end

    // vertex coordinates
    always_comb begin
        logic [FB:0]         mu;
        logic [2:0]          so;
        logic [2:0]          bo;
        logic [IDX_W:0]      ca;
        logic [IDX_W+FB:0]   cf;
        t_coord              c;
        t_coord              mux;
        n_out.fin = r_dh[FB].fin;
        for (int v = 0; v < 3; v++) begin
            mu  = r_dl[FB][v].use_div ? {1'b0, r_dl[FB][v].q} : r_dl[FB][v].preset;
            mux = {{(CW - FB - 1){1'b0}}, mu};
            so  = corner_off(r_dl[FB][v].s);
            bo  = corner_off(r_dl[FB][v].bb);
            for (int k = 0; k < 3; k++) begin
                ca = {1'b0, r_dh[FB].base[k]} + {{IDX_W{1'b0}}, so[k]};
                cf = {ca, {FB{1'b0}}};
                c  = cf[CW-1:0];
                if (bo[k] && !so[k]) begin
                    c = c + mux;
                end else if (!bo[k] && so[k]) begin
                    c = c - mux;
                end
                n_out.v[v][k] = c;
            end
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
            for (int k = 0; k <= FB; k++) begin
                r_dv[k] <= 1'b0;
            end
        end else if (adv) begin
            r_v1    <= issue;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_dv[0] <= r_v3;
            for (int k = 0; k < FB; k++) begin
                r_dv[k+1] <= r_dv[k];
            end
            r_ov <= r_dv[FB];
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_h1.fin  <= (rest == '0);
            r_h1.base <= r_cur.base;
            r_l1      <= n_l1;
            r_h2      <= r_h1;
            r_l2      <= n_l2;
            r_h3      <= r_h2;
            r_l3      <= n_l3;
            r_dh[0]   <= r_h3;
            r_dl[0]   <= n_d0;
            for (int k = 0; k < FB; k++) begin
                r_dh[k+1] <= r_dh[k];
                r_dl[k+1] <= n_dl[k];
            end
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/marching_tetrahedra_cell_triangulator_top.sv]
// Top level of the marching-tetrahedra cell triangulator.
// Depends on mtt_pkg, mtt_front, mtt_queue and mtt_back.
//
//   channel  | handshake                  | carries
//   ---------+----------------------------+----------------------------------
//   in       | i_in_valid / o_in_ready    | cell_x/y/z, corner_0..7
//   out      | o_out_valid / i_out_ready  | va/vb/vc x,y,z, final_triangle
//   cfg      | i_cfg_we (no wait)         | i_cfg_idx, i_cfg_data
//
// The back end issues the triangle jobs of a cell one triangle per cycle unless the
// output stalls, and a cell yields 1 to 12 triangles; empty cells stop at the front.
// A triangle passes the front register, the queue, the issue, difference and snapping
// registers, the divider pipeline (one quotient bit per stage) and the output register.
// Reset is synchronous, active low, and clears queue and pipeline valids. An output stall
// freezes the back end; the front keeps taking cells until the four-entry queue is full.
`default_nettype none

module marching_tetrahedra_cell_triangulator_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mtt_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mtt_pkg::VAL_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  mtt_pkg::t_idx                 i_cell_x,
    input  mtt_pkg::t_idx                 i_cell_y,
    input  mtt_pkg::t_idx                 i_cell_z,
    input  mtt_pkg::t_val                 i_corner_0,
    input  mtt_pkg::t_val                 i_corner_1,
    input  mtt_pkg::t_val                 i_corner_2,
    input  mtt_pkg::t_val                 i_corner_3,
    input  mtt_pkg::t_val                 i_corner_4,
    input  mtt_pkg::t_val                 i_corner_5,
    input  mtt_pkg::t_val                 i_corner_6,
    input  mtt_pkg::t_val                 i_corner_7,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output mtt_pkg::t_coord               o_va_x,
    output mtt_pkg::t_coord               o_va_y,
    output mtt_pkg::t_coord               o_va_z,
    output mtt_pkg::t_coord               o_vb_x,
    output mtt_pkg::t_coord               o_vb_y,
    output mtt_pkg::t_coord               o_vb_z,
    output mtt_pkg::t_coord               o_vc_x,
    output mtt_pkg::t_coord               o_vc_y,
    output mtt_pkg::t_coord               o_vc_z,
    output logic                          o_final_triangle
);
    import mtt_pkg::*;

    t_val             r_iso;
    logic [TOL_W-1:0] r_tol;

    logic             f_push;
    t_cell            f_cell;
    logic             q_ready;
    logic             q_valid;
    t_cell            q_cell;
    logic             q_pop;
    t_tri             tri_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iso <= '0;
            r_tol <= TOL_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ISO_LEVEL: r_iso <= i_cfg_data;
                CFG_SNAP_TOL:  r_tol <= i_cfg_data[TOL_W-1:0];
                default:       r_iso <= r_iso;
            endcase
        end
    end

    mtt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_cell_x   (i_cell_x),
        .i_cell_y   (i_cell_y),
        .i_cell_z   (i_cell_z),
        .i_corner   ({i_corner_7, i_corner_6, i_corner_5, i_corner_4,
                      i_corner_3, i_corner_2, i_corner_1, i_corner_0}),
        .i_iso      (r_iso),
        .o_push     (f_push),
        .o_cell     (f_cell),
        .i_q_ready  (q_ready)
    );

    mtt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_cell  (f_cell),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cell  (q_cell)
    );

    mtt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cell    (q_cell),
        .o_q_pop     (q_pop),
        .i_iso       (r_iso),
        .i_tol       (r_tol),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_tri       (tri_out)
    );

    assign o_va_x           = tri_out.v[0][0];
    assign o_va_y           = tri_out.v[0][1];
    assign o_va_z           = tri_out.v[0][2];
    assign o_vb_x           = tri_out.v[1][0];
    assign o_vb_y           = tri_out.v[1][1];
    assign o_vb_z           = tri_out.v[1][2];
    assign o_vc_x           = tri_out.v[2][0];
    assign o_vc_y           = tri_out.v[2][1];
    assign o_vc_z           = tri_out.v[2][2];
    assign o_final_triangle = tri_out.fin;

endmodule

`default_nettype wire

[hw/rtl/mtt_checker.sv]
// Port-level checks of the triangulator, bound to the top level.
// Depends on mtt_pkg and the assertion macro header.
`default_nettype none

`include "marching_tetrahedra_cell_triangulator_top_macros.svh"

module mtt_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            o_in_ready,
    input logic            o_out_valid,
    input logic            i_out_ready,
    input mtt_pkg::t_coord o_va_x,
    input mtt_pkg::t_coord o_vc_z,
    input logic            o_final_triangle
);
    import mtt_pkg::*;

    // nothing in flight straight after reset
    `MTT_ASSERT_RST(a_out_idle_after_reset, i_clk, !i_rst_n |=> !o_out_valid)
    `MTT_ASSERT_RST(a_ready_after_reset, i_clk, !i_rst_n |=> o_in_ready)

    // a stalled triangle stays put
    `MTT_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_va_x) && $stable(o_final_triangle))

    // clamped indices keep vertices inside the grid
    `MTT_ASSERT(a_coord_range, i_clk, i_rst_n, o_out_valid |-> (o_va_x <= COORD_MAX) && (o_vc_z <= COORD_MAX))

endmodule

bind marching_tetrahedra_cell_triangulator_top mtt_checker u_checker (.*);

`default_nettype wire

[sim/marching_tetrahedra_cell_triangulator_top_tb.sv]
// Self-checking bench for the marching-tetrahedra cell triangulator.
// Needs mtt_pkg and the top level of the block; a scoreboard class predicts triangles.
`default_nettype none

module marching_tetrahedra_cell_triangulator_top_tb;
    import mtt_pkg::*;

    localparam int N_RANDOM  = 360;
    localparam int CYC_LIMIT = 400000;
    localparam int DRAIN_CYC = 60;

    // register index that the block does not decode
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    typedef struct {
        logic [2:0][IDX_W-1:0] base;
        logic [7:0][VAL_W-1:0] val;
    } t_cell_in;

    // Triangle predictor and store of expected triangles
    class tri_scoreboard;
        logic signed [VAL_W-1:0] lvl;
        logic [TOL_W-1:0]        tol;
        t_tri                    pending[$];
        int                      n_bad;

        function new();
            lvl   = '0;
            tol   = 16'd1;
            n_bad = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] d);
            if (idx == CFG_ISO_LEVEL) lvl = d;
            else if (idx == CFG_SNAP_TOL) tol = d[TOL_W-1:0];
        endfunction

        function logic [2:0][CW-1:0] vertex(t_cell_in c, logic [2:0] a, logic [2:0] b);
            logic signed [DW:0] va, vb, num, den, da, db, dv;
            logic [63:0] n, d, mu;
            logic [2:0] oa, ob, src;
            logic [CW-1:0] ca, cb;
            logic [2:0][CW-1:0] r;
            logic interp;
            va = $signed(c.val[a]);
            vb = $signed(c.val[b]);
            da = lvl - va; if (da < 0) da = -da;
            db = lvl - vb; if (db < 0) db = -db;
            dv = va - vb; if (dv < 0) dv = -dv;
            interp = 0; src = a; mu = 0;
            if (da < tol) src = a;
            else if (db < tol) src = b;
            else if (dv < tol || va == vb) src = a;
            else begin
                interp = 1;
                num = lvl - va; den = vb - va;
                if (num != 0 && ((num < 0) == (den < 0))) begin
                    n = (num < 0) ? -num : num;
                    d = (den < 0) ? -den : den;
                    if (n >= d) mu = 64'd1 << FB;
                    else mu = ((n << FB) + (d >> 1)) / d;
                    if (mu > (64'd1 << FB)) mu = 64'd1 << FB;
                end
            end
            oa = corner_off_tb(interp ? a : src);
            ob = corner_off_tb(b);
            for (int k = 0; k < 3; k++) begin
                ca = CW'(c.base[k] + oa[k]) << FB;
                cb = CW'(c.base[k] + ob[k]) << FB;
                if (interp && ob[k] && !oa[k]) ca = ca + CW'(mu);
                else if (interp && oa[k] && !ob[k]) ca = ca - CW'(mu);
                r[k] = ca;
            end
            return r;
        endfunction

        // Offsets as {dz,dy,dx}, cube corner numbering of the cell
        function logic [2:0] corner_off_tb(logic [2:0] c);
            logic [2:0] t [8] = '{3'b000, 3'b010, 3'b011, 3'b001,
                                  3'b100, 3'b110, 3'b111, 3'b101};
            return t[c];
        endfunction

        // Note an accepted cell and queue its triangles
        function void note_cell(t_cell_in c);
            int tc [6][4] = '{'{0,2,3,7}, '{0,2,6,7}, '{0,4,6,7},
                              '{0,6,1,2}, '{0,6,1,4}, '{5,6,1,4}};
            int cnt [16] = '{0,1,1,2,1,2,2,1,1,2,2,1,2,1,1,0};
            logic [7:0] ed [16][6] = '{
                '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
                '{8'h01,8'h02,8'h03,8'h00,8'h00,8'h00},
                '{8'h10,8'h13,8'h12,8'h00,8'h00,8'h00},
                '{8'h03,8'h02,8'h13,8'h13,8'h12,8'h02},
                '{8'h20,8'h21,8'h23,8'h00,8'h00,8'h00},
                '{8'h01,8'h23,8'h03,8'h01,8'h12,8'h23},
                '{8'h01,8'h13,8'h23,8'h01,8'h02,8'h23},
                '{8'h30,8'h32,8'h31,8'h00,8'h00,8'h00},
                '{8'h30,8'h32,8'h31,8'h00,8'h00,8'h00},
                '{8'h01,8'h13,8'h23,8'h01,8'h02,8'h23},
                '{8'h01,8'h23,8'h03,8'h01,8'h12,8'h23},
                '{8'h20,8'h21,8'h23,8'h00,8'h00,8'h00},
                '{8'h03,8'h02,8'h13,8'h13,8'h12,8'h02},
                '{8'h10,8'h13,8'h12,8'h00,8'h00,8'h00},
                '{8'h01,8'h02,8'h03,8'h00,8'h00,8'h00},
                '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00}};
            int n;
            logic [3:0] idx;
            logic [7:0] e;
            t_tri tr;
            n = 0;
            for (int k = 0; k < 3; k++)
                if (c.base[k] > CELL_INDEX_MAX) c.base[k] = IDX_W'(CELL_INDEX_MAX);
            for (int t = 0; t < 6; t++) begin
                idx = '0;
                for (int v = 0; v < 4; v++)
                    if ($signed(c.val[tc[t][v]]) < lvl) idx[v] = 1'b1;
                for (int r = 0; r < cnt[idx]; r++) begin
                    for (int v = 0; v < 3; v++) begin
                        e = ed[idx][r*3+v];
                        tr.v[v] = vertex(c, 3'(tc[t][e[5:4]]), 3'(tc[t][e[1:0]]));
                    end
                    tr.fin = 1'b0;
                    pending.insert(pending.size(), tr);
                    n++;
                end
            end
            if (n > 0) pending[$].fin = 1'b1;
        endfunction

        // Compare one accepted triangle with the oldest expectation
        function void check_tri(t_tri got);
            t_tri exp_tri;
            if (pending.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("unexpected triangle %p", got);
                return;
            end
            exp_tri = pending.pop_front();
            for (int v = 0; v < 3; v++)
                for (int k = 0; k < 3; k++)
                    if (got.v[v][k] !== exp_tri.v[v][k]) begin
                        n_bad++;
                        if (n_bad <= 10)
                            $display("vertex %0d axis %0d: expected %h got %h",
                                     v, k, exp_tri.v[v][k], got.v[v][k]);
                    end
            if (got.fin !== exp_tri.fin) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("final flag: expected %b got %b", exp_tri.fin, got.fin);
            end
        endfunction
    endclass

    logic i_clk, i_rst_n, i_cfg_we, i_in_valid, o_in_ready, o_out_valid, i_out_ready;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [VAL_W-1:0] i_cfg_data;
    t_idx i_cell_x, i_cell_y, i_cell_z;
    t_val i_corner [8];
    t_coord o_v [9];
    logic o_final_triangle;

    tri_scoreboard sb;
    int  cyc;
    int  in_idle_pct, out_idle_pct;
    bit  hold_out;

    marching_tetrahedra_cell_triangulator_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_cell_x(i_cell_x), .i_cell_y(i_cell_y), .i_cell_z(i_cell_z),
        .i_corner_0(i_corner[0]), .i_corner_1(i_corner[1]),
        .i_corner_2(i_corner[2]), .i_corner_3(i_corner[3]),
        .i_corner_4(i_corner[4]), .i_corner_5(i_corner[5]),
        .i_corner_6(i_corner[6]), .i_corner_7(i_corner[7]),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_va_x(o_v[0]), .o_va_y(o_v[1]), .o_va_z(o_v[2]),
        .o_vb_x(o_v[3]), .o_vb_y(o_v[4]), .o_vb_z(o_v[5]),
        .o_vc_x(o_v[6]), .o_vc_y(o_v[7]), .o_vc_z(o_v[8]),
        .o_final_triangle(o_final_triangle)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Cycle count and timeout
    initial begin
        cyc = 0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc > CYC_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                t_tri got;
                for (int v = 0; v < 3; v++)
                    for (int k = 0; k < 3; k++) got.v[v][k] = o_v[v*3+k];
                got.fin = o_final_triangle;
                sb.check_tri(got);
            end
            i_out_ready <= !hold_out && ($urandom_range(99) >= out_idle_pct);
        end
    end

    // One register write; returns in the cycle after the write enable drops
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] d);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_reg(idx, d);
        @(posedge i_clk);
    endtask

    // Offer one cell and wait for it to be taken; valid stays high on return
    task automatic send_cell(t_cell_in c);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cell_x <= c.base[0]; i_cell_y <= c.base[1]; i_cell_z <= c.base[2];
        for (int i = 0; i < 8; i++) i_corner[i] <= c.val[i];
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_cell(c);
    endtask

    // Wait till every expected triangle is out, then let the pipeline settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    // Corners near the level, so edges cross and snapping gets exercised
    function automatic t_cell_in rand_cell(int spread);
        t_cell_in c;
        for (int k = 0; k < 3; k++)
            c.base[k] = ($urandom_range(9) == 0) ? IDX_W'($urandom_range(1023, 1020))
                                                 : IDX_W'($urandom);
        for (int i = 0; i < 8; i++)
            c.val[i] = (spread == 0) ? t_val'($urandom)
                     : t_val'($signed(sb.lvl) + $signed($urandom_range(2*spread) - spread));
        return c;
    endfunction

    initial begin
        t_cell_in c;
        logic [VAL_W-1:0] lvls [4] = '{32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_8000};
        logic [VAL_W-1:0] tols [4] = '{32'd1, 32'd0, 32'hFFFF, 32'd300};
        sb = new();
        hold_out = 1'b0;
        in_idle_pct = 21; out_idle_pct = 21;
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        i_in_valid = 1'b0; i_cell_x = '0; i_cell_y = '0; i_cell_z = '0;
        for (int i = 0; i < 8; i++) i_corner[i] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes of every field, empty cells, single-corner cases
        c.base = '{IDX_W'(0), IDX_W'(0), IDX_W'(0)};
        c.val = '{default: 32'h0001_0000};
        send_cell(c);
        c.val = '{default: 32'h8000_0000};
        send_cell(c);
        c.base = '{IDX_W'(1023), IDX_W'(1022), IDX_W'(1023)};
        for (int k = 0; k < 16; k++) begin
            for (int i = 0; i < 8; i++)
                c.val[i] = ((k >> (i % 4)) & 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            if (k > 7) c.val[k-8] = 32'hFFFF_FFFF;
            send_cell(c);
        end
        c.val = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h0, 32'h2, 32'hFFFF_FFFE, 32'h0, 32'h1};
        send_cell(c);
        // invalid register index must be ignored
        drain();
        write_reg(CFG_UNUSED_IDX, 32'hDEAD_BEEF);

        // Random phases across level and tolerance settings
        for (int ph = 0; ph < 4; ph++) begin
            drain();
            write_reg(CFG_ISO_LEVEL, lvls[ph]);
            write_reg(CFG_SNAP_TOL, tols[ph]);
            in_idle_pct  = (ph == 2) ? 0 : 21;
            out_idle_pct = (ph == 2) ? 0 : 21;
            for (int n = 0; n < N_RANDOM / 4; n++) begin
                if (ph == 1 && n == 10) fork
                    begin hold_out = 1'b1; repeat (200) @(posedge i_clk); hold_out = 1'b0; end
                join_none
                case ($urandom_range(3))
                    0: c = rand_cell(0);
                    1: c = rand_cell(4);
                    2: c = rand_cell(400);
                    default: c = rand_cell(200000);
                endcase
                send_cell(c);
            end
        end
        hold_out = 1'b0;
        drain();
        if (sb.n_bad == 0 && sb.pending.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

`default_nettype wire
